// ----- src/lsdd_pkg.sv -----
// ----------------------------------------------------------------------------
// lsdd_pkg
// Shared types, widths, scaling constants and DAC frame builders for the
// electronic load setpoint DAC driver.
// ----------------------------------------------------------------------------
package lsdd_pkg;

   localparam int SP_W       = 24;
   localparam int CODE_W     = 16;
   localparam int FRAME_W    = 32;
   localparam int RELAY_W    = 2;
   localparam int BYTE_W     = 8;
   localparam int NIB_W      = 4;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 1;
   localparam int RSP_PAD_W  = RSP_DATA_W - FRAME_W - RELAY_W - CODE_W;

   localparam int unsigned RANGE_THRESHOLD_UA_DEF = 30000;

   // Scale by reciprocal: code = (sp * K) >> SHIFT, K rounded up.
   localparam int K_W      = 34;
   localparam int PROD_W   = SP_W + K_W;
   localparam int SHIFT_LO = 31;
   localparam int SHIFT_HI = 45;
   localparam int LO_Q_W   = PROD_W - SHIFT_LO;
   localparam int HI_Q_W   = PROD_W - SHIFT_HI;
   localparam logic [K_W-1:0] K_LO = 34'd1125899907;   // 2^44 / 15625
   localparam logic [K_W-1:0] K_HI = 34'd9223372037;   // 2^54 / 1953125

   localparam logic [RELAY_W-1:0] RELAY_INIT = 2'd0;
   localparam logic [RELAY_W-1:0] RELAY_HIGH = 2'd1;
   localparam logic [RELAY_W-1:0] RELAY_LOW  = 2'd2;

   localparam logic [BYTE_W-1:0] OP_WRITE     = 8'h00;
   localparam logic [BYTE_W-1:0] OP_POWER     = 8'h04;
   localparam logic [BYTE_W-1:0] PWR_UP       = 8'h00;
   localparam logic [BYTE_W-1:0] PWR_DOWN     = 8'h02;
   localparam logic [BYTE_W-1:0] PWR_SEL_CH1  = 8'h0C;
   localparam logic [BYTE_W-1:0] PWR_SEL_CH0  = 8'h03;
   localparam logic [NIB_W-1:0]  WR_SEL_CH1   = 4'h3;
   localparam logic [NIB_W-1:0]  WR_SEL_CH0   = 4'h0;

   typedef enum logic [0:0] {
      CMD_CURRENT = 1'b0,
      CMD_DIRECT  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                    frame_valid;
      logic                    two;
      logic [FRAME_W-1:0]      frame0;
      logic [FRAME_W-1:0]      frame1;
      logic [RELAY_W-1:0]      relay;
      logic [CODE_W-1:0]       code;
   } rsp_slot_type;

   function automatic logic [FRAME_W-1:0] write_frame(input logic ch,
                                                      input logic [CODE_W-1:0] code);
      logic [NIB_W-1:0] sel;
      sel = ch ? WR_SEL_CH1 : WR_SEL_CH0;
      return {OP_WRITE, sel, code[15:12], code[11:4], code[3:0], {NIB_W{1'b0}}};
   endfunction

   function automatic logic [FRAME_W-1:0] power_frame(input logic ch, input logic up);
      logic [BYTE_W-1:0] mode;
      logic [BYTE_W-1:0] sel;
      mode = up ? PWR_UP : PWR_DOWN;
      sel  = ch ? PWR_SEL_CH1 : PWR_SEL_CH0;
      return {OP_POWER, {BYTE_W{1'b0}}, mode, sel};
   endfunction

endpackage

// ----- src/load_setpoint_dac_driver.sv -----
// ----------------------------------------------------------------------------
// load_setpoint_dac_driver
// Turns current setpoints and direct code writes into DAC command frames and
// range relay state for an electronic load.
// ----------------------------------------------------------------------------
// Path: a request is registered in stage 1, then stage 2, then the result register.
// Throughput: one request per cycle while rsp_tready is high and it yields one result;
//   a request that yields two frames holds the result register until both are taken.
// Scaling uses one 24x34 reciprocal multiply between stage 1 and stage 2.
// Reset: synchronous, clears the pipeline, relay state, last code and power.
module load_setpoint_dac_driver #(
   parameter int unsigned RANGE_THRESHOLD_UA = lsdd_pkg::RANGE_THRESHOLD_UA_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsdd_pkg::REQ_DATA_W-1:0]   req_tdata,   // [23:0] setpoint
   input  logic [lsdd_pkg::REQ_USER_W-1:0]   req_tuser,   // [0] cmd, [1] channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsdd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [31:0] frame, [33:32]
                                                          // relay_state,
                                                          // [49:34] dac_code, pad
   output logic [lsdd_pkg::RSP_USER_W-1:0]   rsp_tuser,   // [0] frame_valid
   output logic                              rsp_tlast
);

   localparam int SpW = lsdd_pkg::SP_W;
   localparam logic [SpW-1:0] Threshold = SpW'(RANGE_THRESHOLD_UA);

   // stage 1
   logic                       s1_vld_ff, s1_vld_in;
   lsdd_pkg::cmd_type          s1_cmd_ff;
   logic                       s1_ch_ff;
   logic                       s1_hi_ff;
   logic [SpW-1:0]             s1_sp_ff;
   // stage 2
   logic                       s2_vld_ff, s2_vld_in;
   lsdd_pkg::cmd_type          s2_cmd_ff;
   logic                       s2_ch_ff;
   logic                       s2_hi_ff;
   logic [SpW-1:0]             s2_sp_ff;
   logic [lsdd_pkg::CODE_W-1:0] s2_code_ff, s2_code_in;
   // result register
   logic                       out_vld_ff, out_vld_in;
   logic                       out_idx_ff, out_idx_in;
   lsdd_pkg::rsp_slot_type     out_slot_ff, out_slot_in;
   // load state
   logic [SpW-1:0]              last_current_ff, last_current_in;
   logic [lsdd_pkg::CODE_W-1:0] last_code_ff, last_code_in;
   logic [lsdd_pkg::RELAY_W-1:0] relay_ff, relay_in;
   logic [1:0]                  powered_ff, powered_in;

   logic                       rsp_acc, out_done, out_free;
   logic                       s2_move, s2_free, s1_move, s1_free, req_acc;
   logic [lsdd_pkg::K_W-1:0]    mult_k;
   logic [lsdd_pkg::PROD_W-1:0] prod;
   logic [lsdd_pkg::LO_Q_W-1:0] q_lo;
   logic [lsdd_pkg::HI_Q_W-1:0] q_hi;

   logic                        drive_ch, drive_en, code_changed, is_current;
   logic [lsdd_pkg::CODE_W-1:0] drive_code;
   logic [lsdd_pkg::FRAME_W-1:0] wr_frame;

   // flow control
   assign rsp_acc    = out_vld_ff & rsp_tready;
   assign out_done   = rsp_acc & (~out_slot_ff.two | out_idx_ff);
   assign out_free   = ~out_vld_ff | out_done;
   assign s2_move    = s2_vld_ff & out_free;
   assign s2_free    = ~s2_vld_ff | s2_move;
   assign s1_move    = s1_vld_ff & s2_free;
   assign s1_free    = ~s1_vld_ff | s1_move;
   assign req_tready = s1_free;
   assign req_acc    = req_tvalid & s1_free;

   assign s1_vld_in  = req_acc | (s1_vld_ff & ~s1_move);
   assign s2_vld_in  = s1_move | (s2_vld_ff & ~s2_move);
   assign out_vld_in = s2_move | (out_vld_ff & ~out_done);

   always_comb begin
      out_idx_in = out_idx_ff;
      if (s2_move) begin
         out_idx_in = 1'b0;
      end else if (rsp_acc) begin
         out_idx_in = 1'b1;
      end
   end

   // scale setpoint to DAC code
   assign mult_k = s1_hi_ff ? lsdd_pkg::K_HI : lsdd_pkg::K_LO;
   assign prod   = {{lsdd_pkg::K_W{1'b0}}, s1_sp_ff} * {{SpW{1'b0}}, mult_k};
   assign q_lo   = prod[lsdd_pkg::PROD_W-1:lsdd_pkg::SHIFT_LO];
   assign q_hi   = prod[lsdd_pkg::PROD_W-1:lsdd_pkg::SHIFT_HI];

   always_comb begin
      if (s1_hi_ff) begin
         s2_code_in = lsdd_pkg::CODE_W'(q_hi);
      end else if (|q_lo[lsdd_pkg::LO_Q_W-1:lsdd_pkg::CODE_W]) begin
         s2_code_in = '1;
      end else begin
         s2_code_in = q_lo[lsdd_pkg::CODE_W-1:0];
      end
   end

   // apply to load state and build frames
   assign is_current   = (s2_cmd_ff == lsdd_pkg::CMD_CURRENT);
   assign code_changed = (s2_code_ff != last_code_ff);
   assign drive_ch     = is_current ? 1'b1 : s2_ch_ff;
   assign drive_code   = is_current ? s2_code_ff : s2_sp_ff[lsdd_pkg::CODE_W-1:0];
   assign drive_en     = ~is_current | code_changed;
   assign wr_frame     = lsdd_pkg::write_frame(drive_ch, drive_code);

   always_comb begin
      relay_in        = relay_ff;
      last_current_in = last_current_ff;
      last_code_in    = last_code_ff;
      powered_in      = powered_ff;
      if (is_current) begin
         if (s2_hi_ff) begin
            if (last_current_ff < Threshold) begin
               relay_in = lsdd_pkg::RELAY_HIGH;
            end
         end else if (last_current_ff >= Threshold) begin
            relay_in = lsdd_pkg::RELAY_LOW;
         end
         if (code_changed) begin
            last_current_in = s2_sp_ff;
            last_code_in    = s2_code_ff;
         end
      end
      if (drive_en) begin
         powered_in[drive_ch] = (drive_code != '0);
      end
   end

   always_comb begin
      out_slot_in             = '0;
      out_slot_in.relay       = relay_in;
      out_slot_in.code        = last_code_in;
      out_slot_in.frame_valid = drive_en;
      if (drive_en) begin
         priority if (drive_code == '0) begin
            out_slot_in.frame0 = lsdd_pkg::power_frame(drive_ch, 1'b0);
         end else if (!powered_ff[drive_ch]) begin
            out_slot_in.frame0 = lsdd_pkg::power_frame(drive_ch, 1'b1);
            out_slot_in.frame1 = wr_frame;
            out_slot_in.two    = 1'b1;
         end else begin
            out_slot_in.frame0 = wr_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
         out_idx_ff      <= 1'b0;
         last_current_ff <= '0;
         last_code_ff    <= '0;
         relay_ff        <= lsdd_pkg::RELAY_INIT;
         powered_ff      <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
         out_idx_ff <= out_idx_in;
         if (s2_move) begin
            last_current_ff <= last_current_in;
            last_code_ff    <= last_code_in;
            relay_ff        <= relay_in;
            powered_ff      <= powered_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff <= lsdd_pkg::cmd_type'(req_tuser[0]);
         s1_ch_ff  <= req_tuser[1];
         s1_sp_ff  <= req_tdata;
         s1_hi_ff  <= (req_tdata >= Threshold);
      end
      if (s1_move) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_ch_ff   <= s1_ch_ff;
         s2_sp_ff   <= s1_sp_ff;
         s2_hi_ff   <= s1_hi_ff;
         s2_code_ff <= s2_code_in;
      end
      if (s2_move) begin
         out_slot_ff <= out_slot_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = ~out_slot_ff.two | out_idx_ff;
   assign rsp_tuser  = out_slot_ff.frame_valid;
   assign rsp_tdata  = {{lsdd_pkg::RSP_PAD_W{1'b0}}, out_slot_ff.code, out_slot_ff.relay,
                        (out_idx_ff ? out_slot_ff.frame1 : out_slot_ff.frame0)};

endmodule

// ----- src/lsdd_checker.sv -----
// ----------------------------------------------------------------------------
// lsdd_checker
// Port-level checks on the result stream of the setpoint DAC driver.
// ----------------------------------------------------------------------------
module lsdd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lsdd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [lsdd_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input logic                              rsp_tlast
);

   a_no_frame_single : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[31:0] == '0))
      else $error("result without frame is not single or carries data");

   a_first_is_power_up : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser[0] && (rsp_tdata[31:24] == lsdd_pkg::OP_POWER) &&
         (rsp_tdata[15:8] == lsdd_pkg::PWR_UP))
      else $error("leading result of a pair is not a power-up frame");

   a_write_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser[0] && rsp_tlast &&
         (rsp_tdata[31:24] == lsdd_pkg::OP_WRITE))
      else $error("power-up frame not followed by a write frame");

   a_relay_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] != 2'd3) &&
         (rsp_tdata[lsdd_pkg::RSP_DATA_W-1:50] == '0))
      else $error("bad relay state or nonzero padding");

   a_hold_stalled : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind load_setpoint_dac_driver lsdd_checker u_lsdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
